>>> design/upc_pkg.sv
// upc_pkg: shared types, character constants and helper functions
// for the url percent codec; no dependencies
package upc_pkg;

	// character constants
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	// command queue depth
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	// what the back end must emit for one queued command
	typedef enum logic [2:0] {
		CMD_ONE  = 3'b001,  // one byte
		CMD_HEX  = 3'b010,  // percent plus two hex digits
		CMD_MARK = 3'b100   // bare end marker
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic passes_unchanged(input logic [7:0] c);
		return (c >= CH_D0 && c <= CH_D9) || (c >= CH_LA && c <= CH_LZ) ||
			(c >= CH_UA && c <= CH_UZ) || c == CH_DASH || c == CH_UNDER ||
			c == CH_DOT || c == CH_TILDE;
	endfunction

	// loose nibble rule: digits give their value, anything else folds to
	// lower case and gives c - 'a' + 10 modulo 256
	function automatic logic [7:0] nibble(input logic [7:0] c);
		logic [7:0] f;
		f = c;
		if (c >= CH_D0 && c <= CH_D9)
			return c - CH_D0;
		if (c >= CH_UA && c <= CH_UZ)
			f = c + 8'd32;
		return f - CH_LA + 8'd10;
	endfunction

endpackage

>>> design/upc_front.sv
// upc_front: accepts input words, tracks the decode escape state and
// turns each word into at most one command; depends on upc_pkg
module upc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              encode_mode,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              push,
	output upc_pkg::cmd_t     push_cmd
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_DIG  = 3'b100
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] first_q, first_d;
	logic       accept;
	logic [7:0] plain_byte;
	logic [7:0] hi_nib;

	assign accept     = in_valid && !in_stall;
	assign plain_byte = (in_byte == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : in_byte;
	assign hi_nib     = upc_pkg::nibble(first_q);

	always_comb begin
		phase_d       = phase_q;
		first_d       = first_q;
		push          = 1'b0;
		push_cmd.kind = upc_pkg::CMD_ONE;
		push_cmd.data = in_byte;
		push_cmd.last = in_last;
		if (accept) begin
			if (encode_mode) begin
				phase_d = PH_IDLE;
				push    = 1'b1;
				if (upc_pkg::passes_unchanged(in_byte)) begin
					push_cmd.kind = upc_pkg::CMD_ONE;
				end else if (in_byte == upc_pkg::CH_SPACE) begin
					push_cmd.data = upc_pkg::CH_PLUS;
				end else begin
					push_cmd.kind = upc_pkg::CMD_HEX;
				end
			end else begin
				case (phase_q)
					PH_PCT: begin
						if (in_last) begin
							push = 1'b1;
							if (in_byte == upc_pkg::CH_PCT) begin
								push_cmd.kind = upc_pkg::CMD_MARK;
								push_cmd.data = 8'h00;
							end else begin
								push_cmd.data = plain_byte;
							end
						end else begin
							first_d = in_byte;
							phase_d = PH_DIG;
						end
					end
					PH_DIG: begin
						push          = 1'b1;
						push_cmd.data = {hi_nib[3:0], 4'b0000} | upc_pkg::nibble(in_byte);
						phase_d       = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
						if (in_byte == upc_pkg::CH_PCT) begin
							if (in_last) begin
								push          = 1'b1;
								push_cmd.kind = upc_pkg::CMD_MARK;
								push_cmd.data = 8'h00;
							end else begin
								phase_d = PH_PCT;
							end
						end else begin
							push          = 1'b1;
							push_cmd.data = plain_byte;
						end
					end
				endcase
			end
			if (in_last)
				phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= 8'h00;
		end else begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

endmodule

>>> design/upc_queue.sv
// upc_queue: short command queue between front and back end
// depends on upc_pkg
module upc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  upc_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output upc_pkg::cmd_t      head_cmd,
	output upc_pkg::q_status_t status
);

	upc_pkg::cmd_t                mem_q [upc_pkg::Q_DEPTH];
	logic [upc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [upc_pkg::QCNT_W-1:0]   count_q;

	localparam logic [upc_pkg::QPTR_W-1:0] PTR_MAX = upc_pkg::QPTR_W'(upc_pkg::Q_DEPTH - 1);

	assign status.full  = (count_q == upc_pkg::QCNT_W'(upc_pkg::Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/upc_back.sv
// upc_back: takes commands from the queue and emits result words,
// up to three per command, through an output register; depends on upc_pkg
module upc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upc_pkg::cmd_t      head_cmd,
	input  upc_pkg::q_status_t status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               has_byte,
	output logic               run_end,
	output logic               string_end
);

	logic [1:0] step_q;
	logic       load;
	logic       fin;
	logic [7:0] w_byte;
	logic       w_has;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_q, run_end_q, str_end_q;

	assign load = !status.empty && (!out_valid_q || !out_stall);

	always_comb begin
		fin    = 1'b1;
		w_byte = head_cmd.data;
		w_has  = 1'b1;
		case (head_cmd.kind)
			upc_pkg::CMD_HEX: begin
				case (step_q)
					2'd0: begin
						w_byte = upc_pkg::CH_PCT;
						fin    = 1'b0;
					end
					2'd1: begin
						w_byte = upc_pkg::HEX_DIGITS[head_cmd.data[7:4]];
						fin    = 1'b0;
					end
					default: w_byte = upc_pkg::HEX_DIGITS[head_cmd.data[3:0]];
				endcase
			end
			upc_pkg::CMD_MARK: begin
				w_byte = 8'h00;
				w_has  = 1'b0;
			end
			default: w_byte = head_cmd.data;
		endcase
	end

	assign pop = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load)
				step_q <= fin ? 2'd0 : step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= w_byte;
			has_q      <= w_has;
			run_end_q  <= fin;
			str_end_q  <= fin && head_cmd.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign has_byte   = has_q;
	assign run_end    = run_end_q;
	assign string_end = str_end_q;

endmodule

>>> design/url_percent_codec_unit.sv
// url_percent_codec_unit: top level of the url percent codec
// depends on upc_pkg, upc_front, upc_queue, upc_back
//
// Byte-stream URL codec in the form-urlencoded style. With encode_mode at 0
// it decodes ('+' gives a space, '%' and two characters give one byte); at 1
// it encodes (letters, digits and - _ . ~ pass, space gives '+', any other
// byte gives '%' and two lower-case hex digits). The mode register is
// written through cfg_we/cfg_data; the user must write it only while the
// block is idle, as the block does not enforce this. Input words are taken
// one per cycle whenever the two-entry command queue has room; the front
// end keeps the escape state. The back end emits one result word per cycle
// while the output is not stalled: one for a plain or decoded byte, three
// for an escaped byte in encode mode, so the output sequencer then sets the
// sustained rate. Words that only advance a pending escape give no result.
// Results pass through the command queue and the output register.
module url_percent_codec_unit (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_end,
	output logic       string_end
);

	logic               encode_mode_q;
	logic               push, pop;
	upc_pkg::cmd_t      push_cmd, head_cmd;
	upc_pkg::q_status_t q_st;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			encode_mode_q <= 1'b0;
		else if (cfg_we)
			encode_mode_q <= cfg_data;
	end

	// the front end waits only on a full queue
	assign in_stall = q_st.full;

	upc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.encode_mode (encode_mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	upc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_st)
	);

	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.status     (q_st),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_st.full)
		else $error("command pushed into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_st.empty)
		else $error("command popped from empty queue");

	// end of string always closes a run
	a_str_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> run_end)
		else $error("string end without run end");

	// a bare marker only ends a string and carries a zero byte
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (string_end && out_byte == 8'h00))
		else $error("malformed bare end marker");

endmodule

>>> test/tb_url_percent_codec_unit.sv
// tb_url_percent_codec_unit: self-checking bench for the url percent codec
// holds its own behavioural predictor; depends on upc_pkg and url_percent_codec_unit
module tb_url_percent_codec_unit;

	localparam int ITEMS_PER_MODE = 50;      // random words per mode and per flow mix
	localparam int SETTLE_CYCLES  = 6;       // covers the path through the queue and output register with margin
	localparam int HOLD_LEN       = 200;     // length of the long output hold
	localparam int CYCLE_LIMIT    = 200000;

	// escape tracking of the decoder, as the predictor sees it
	typedef enum logic [1:0] {
		ESC_IDLE  = 2'd0,  // nothing pending
		ESC_PCT   = 2'd1,  // '%' seen
		ESC_DIGIT = 2'd2   // '%' and the first digit seen
	} esc_phase_t;

	// one result word as it leaves the block
	typedef struct packed {
		logic [7:0] chr;
		logic       has_byte;
		logic       run_end;
		logic       string_end;
	} codec_result_t;

	localparam logic [7:0] SAFE_MARKS [4] = '{upc_pkg::CH_DASH, upc_pkg::CH_UNDER,
		upc_pkg::CH_DOT, upc_pkg::CH_TILDE};

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic       cfg_data   = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte    = 8'h00;
	logic       in_last    = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       run_end;
	logic       string_end;

	// predictor state, a private copy of the mode register and escape tracking
	logic       enc_mode   = 1'b0;
	esc_phase_t esc_phase  = ESC_IDLE;
	logic [7:0] first_char = 8'h00;

	// result words still owed by the block, oldest first
	codec_result_t expected_chars[$];

	// flow control knobs
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic long_hold      = 1'b0;
	int   hold_cnt       = 0;

	int errors          = 0;
	int words_sent      = 0;
	int results_checked = 0;
	int cycle_count     = 0;

	logic [7:0] text_buf[$];

	url_percent_codec_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic void queue_result(input logic [7:0] c, input logic has,
			input logic re, input logic se);
		codec_result_t r;
		r.chr        = c;
		r.has_byte   = has;
		r.run_end    = re;
		r.string_end = se;
		expected_chars.push_back(r);
	endfunction

	// loose hex digit value: decimal digits as they are, anything else folded
	// to lower case and offset from 'a', wrapping at 256
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] folded;
		folded = c;
		if (c >= upc_pkg::CH_D0 && c <= upc_pkg::CH_D9)
			return c - upc_pkg::CH_D0;
		if (c >= upc_pkg::CH_UA && c <= upc_pkg::CH_UZ)
			folded = c + 8'd32;
		return folded - upc_pkg::CH_LA + 8'd10;
	endfunction

	// characters that encoding leaves alone
	function automatic logic is_unreserved(input logic [7:0] c);
		return (c >= upc_pkg::CH_D0 && c <= upc_pkg::CH_D9) ||
			(c >= upc_pkg::CH_LA && c <= upc_pkg::CH_LZ) ||
			(c >= upc_pkg::CH_UA && c <= upc_pkg::CH_UZ) ||
			c == upc_pkg::CH_DASH || c == upc_pkg::CH_UNDER ||
			c == upc_pkg::CH_DOT || c == upc_pkg::CH_TILDE;
	endfunction

	// decode of a character with no escape open
	function automatic void decode_plain_char(input logic [7:0] b, input logic lst);
		if (b == upc_pkg::CH_PCT) begin
			// a percent at the very end is dropped, leaving only the end marker
			if (lst)
				queue_result(8'h00, 1'b0, 1'b1, 1'b1);
			else
				esc_phase = ESC_PCT;
		end else begin
			queue_result((b == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : b, 1'b1, 1'b1, lst);
		end
	endfunction

	// works out every result word caused by one accepted input word
	function automatic void predict_codec(input logic [7:0] b, input logic lst);
		logic [7:0] hi;
		if (enc_mode) begin
			// encoding forgets any escape left open by an earlier decode
			esc_phase = ESC_IDLE;
			if (is_unreserved(b)) begin
				queue_result(b, 1'b1, 1'b1, lst);
			end else if (b == upc_pkg::CH_SPACE) begin
				queue_result(upc_pkg::CH_PLUS, 1'b1, 1'b1, lst);
			end else begin
				queue_result(upc_pkg::CH_PCT, 1'b1, 1'b0, 1'b0);
				queue_result(upc_pkg::HEX_DIGITS[b[7:4]], 1'b1, 1'b0, 1'b0);
				queue_result(upc_pkg::HEX_DIGITS[b[3:0]], 1'b1, 1'b1, lst);
			end
		end else begin
			case (esc_phase)
				ESC_PCT: begin
					if (lst) begin
						// string ends after '%' and one byte: the byte stands alone
						esc_phase = ESC_IDLE;
						decode_plain_char(b, 1'b1);
					end else begin
						first_char = b;
						esc_phase  = ESC_DIGIT;
					end
				end
				ESC_DIGIT: begin
					hi = hex_value(first_char);
					esc_phase = ESC_IDLE;
					queue_result({hi[3:0], 4'h0} | hex_value(b), 1'b1, 1'b1, lst);
				end
				default: begin
					esc_phase = ESC_IDLE;
					decode_plain_char(b, lst);
				end
			endcase
			if (lst)
				esc_phase = ESC_IDLE;
		end
	endfunction

	// ---------------------------------------------------------------
	// shared driving tasks
	// ---------------------------------------------------------------

	// offers one word after a random gap and waits for it to be taken
	task automatic send_char(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_codec(b, lst);
		words_sent++;
	endtask

	// sends text_buf as one string, flagging its final word when asked
	task automatic send_text(input logic ends);
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], ends && (i == text_buf.size() - 1));
	endtask

	// stops offering and waits until every owed word has come back, then lets
	// words that only advance an escape settle inside the block
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we   <= 1'b0;
		enc_mode = m;
	endtask

	function automatic logic [7:0] random_hex_char();
		logic [7:0] c;
		c = upc_pkg::HEX_DIGITS[4'($urandom_range(15))];
		if (c >= upc_pkg::CH_LA && $urandom_range(1) == 1)
			c = c - 8'd32;
		return c;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// decode corner cases: plus, escapes of mixed case, non-hex digits,
	// extreme bytes and every way a string can end inside an escape
	task automatic test_decode_directed();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		set_mode(1'b0);
		send_char("a", 1'b1);
		send_char(upc_pkg::CH_PLUS, 1'b0);
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char("4", 1'b0);
		send_char("a", 1'b0);
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char("g", 1'b0);
		send_char("Z", 1'b0);
		// escape ending the string with extreme, non-hex digits
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h01, 1'b1);
		// lone percent at the end
		send_char(upc_pkg::CH_PCT, 1'b1);
		// percent and one byte at the end, byte being plus then percent
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char(upc_pkg::CH_PLUS, 1'b1);
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char(upc_pkg::CH_PCT, 1'b1);
	endtask

	// encode of upper-case letters, safe marks, space and bytes that need escaping,
	// entered with a decode escape still open, then a check that the escape does not survive the return to decode
	task automatic test_encode_directed();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		send_char(upc_pkg::CH_PCT, 1'b0);
		set_mode(1'b1);
		send_char("Z", 1'b0);
		send_char(upc_pkg::CH_DASH, 1'b0);
		send_char(upc_pkg::CH_TILDE, 1'b0);
		send_char(upc_pkg::CH_SPACE, 1'b0);
		send_char(upc_pkg::CH_PCT, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h01, 1'b1);
		set_mode(1'b0);
		send_char("7", 1'b1);
	endtask

	// random strings in both modes under one mix of sender gaps and
	// receiver stalls; decode strings are mostly well formed
	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int sent;
		int n;
		int kind;
		logic [7:0] b;
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;

		set_mode(1'b0);
		sent = 0;
		while (sent < ITEMS_PER_MODE) begin
			text_buf.delete();
			n = $urandom_range(1, 8);
			repeat (n) begin
				kind = $urandom_range(99);
				if (kind < 35) begin
					b = 8'($urandom_range(1, 255));
					text_buf.push_back((b == upc_pkg::CH_PCT) ? upc_pkg::CH_PLUS : b);
				end else if (kind < 45) begin
					text_buf.push_back(upc_pkg::CH_PLUS);
				end else if (kind < 85) begin
					text_buf.push_back(upc_pkg::CH_PCT);
					text_buf.push_back(random_hex_char());
					text_buf.push_back(random_hex_char());
				end else begin
					// escape with arbitrary digits
					text_buf.push_back(upc_pkg::CH_PCT);
					text_buf.push_back(8'($urandom_range(1, 255)));
					text_buf.push_back(8'($urandom_range(1, 255)));
				end
			end
			// now and then the string stops inside an escape
			kind = $urandom_range(99);
			if (kind < 8) begin
				text_buf.push_back(upc_pkg::CH_PCT);
			end else if (kind < 16) begin
				text_buf.push_back(upc_pkg::CH_PCT);
				text_buf.push_back(8'($urandom_range(1, 255)));
			end
			// a few strings are left open to carry an escape into the next one
			send_text($urandom_range(9) != 0);
			sent += text_buf.size();
		end

		set_mode(1'b1);
		sent = 0;
		while (sent < ITEMS_PER_MODE) begin
			text_buf.delete();
			n = $urandom_range(1, 10);
			repeat (n) begin
				kind = $urandom_range(99);
				if (kind < 50)
					b = 8'($urandom_range(1, 255));
				else if (kind < 60)
					b = 8'($urandom_range(upc_pkg::CH_LA, upc_pkg::CH_LZ));
				else if (kind < 70)
					b = 8'($urandom_range(upc_pkg::CH_UA, upc_pkg::CH_UZ));
				else if (kind < 78)
					b = 8'($urandom_range(upc_pkg::CH_D0, upc_pkg::CH_D9));
				else if (kind < 86)
					b = SAFE_MARKS[2'($urandom_range(3))];
				else if (kind < 93)
					b = upc_pkg::CH_SPACE;
				else
					b = 8'($urandom_range(128, 255));
				text_buf.push_back(b);
			end
			send_text(1'b1);
			sent += text_buf.size();
		end
	endtask

	// the receiver holds off for a long stretch while words keep coming, so
	// the command queue fills and the input side has to stall
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		set_mode(1'b1);
		long_hold <= 1'b1;
		for (int i = 0; i < 24; i++)
			send_char(8'($urandom_range(1, 255)), i == 23);
		wait_idle();
		long_hold <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// receiver, checker and watchdog
	// ---------------------------------------------------------------

	// output stall: the long hold takes priority, otherwise random per cycle
	always @(posedge clk) begin
		if (long_hold && hold_cnt < HOLD_LEN) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			if (!long_hold)
				hold_cnt <= 0;
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// every word taken from the output is matched against the oldest owed word
	always @(posedge clk) begin : check_results
		codec_result_t got;
		codec_result_t want;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got = {out_byte, has_byte, run_end, string_end};
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: result word with none owed, expected none,",
					$time, " got byte %h has %b run %b string %b",
					got.chr, got.has_byte, got.run_end, got.string_end);
			end else begin
				want = expected_chars.pop_front();
				results_checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch, expected byte %h has %b run %b string %b,",
						$time, want.chr, want.has_byte, want.run_end, want.string_end,
						" got byte %h has %b run %b string %b",
						got.chr, got.has_byte, got.run_end, got.string_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result words still owed", $time,
				expected_chars.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence of tests
	// ---------------------------------------------------------------

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_decode_directed();
		test_encode_directed();
		test_random_phase(0, 0);     // full rate both sides
		test_random_phase(88, 0);    // sparse sender
		test_random_phase(0, 88);    // slow receiver
		test_random_phase(22, 22);   // light gaps on both sides
		test_output_hold();

		wait_idle();
		$display("checked %0d result words from %0d input words in decode and encode",
			results_checked, words_sent);
		$display("under four flow-control mixes, one long output hold and many mode changes");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
